### src/mcw_pkg.sv
// Shared types and constants for the minimum covering window block.
package mcw_pkg;

    localparam int MAX_ALPHABET = 16;
    localparam int MAX_TEXT     = 65536;
    localparam int CHAR_W       = 8;
    localparam int POS_W        = 16;
    localparam int LEN_W        = 17;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT - 1);

    localparam logic OP_ALPHA = 1'b0;
    localparam logic OP_TEXT  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_in;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start_res;
        logic [LEN_W-1:0] length;
    } t_out;

endpackage

### src/minimum_covering_window.sv
// Minimum covering window: top level with input and result registers.
//
// Input channel (i_valid / o_stall / i_in): op 0 loads an alphabet byte
// (duplicates and bytes beyond the set size are dropped), op 1 is a text
// byte. A text byte with last set closes the query and yields one result
// transaction on the output channel (o_valid / i_stall / o_out): found,
// start_res and length of the earliest shortest window that holds every
// alphabet byte. An empty alphabet gives found=1, length 0; no window gives
// found=0 with zero start and length. The query, alphabet included, is
// cleared after the result.
// Throughput: one transaction per cycle while o_stall is low. Each item is
// registered, then the match compare, min tree over last-seen positions and
// length compare update the state.
// A result is loaded into the result register when its closing text byte
// advances from the input register; a held result can keep that byte there.
// Reset clears the alphabet, the query and the valid flags of both channel registers.
// A stalled result holds; items that produce no result keep flowing, and
// o_stall rises only when a closing item meets a held result.
module minimum_covering_window (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  mcw_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output mcw_pkg::t_out o_out
);

    logic          r_in_valid;
    mcw_pkg::t_in  r_in;
    logic          r_out_valid;
    mcw_pkg::t_out r_out;
    mcw_pkg::t_out core_res;
    logic          is_res;
    logic          advance;

    assign is_res  = (r_in.op == mcw_pkg::OP_TEXT) && r_in.last;
    assign advance = r_in_valid && !(is_res && r_out_valid && i_stall);
    assign o_stall = r_in_valid && !advance;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    mcw_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance && is_res) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_in;
        end
        if (advance && is_res) begin
            r_out <= core_res;
        end
    end

    // a held item stays put until it can advance
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_stall |=> r_in_valid && $stable(r_in))
        else $error("held input item lost or changed");

    // a closing item that advances always lands in the result register
    a_res_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && is_res |=> r_out_valid)
        else $error("closing item produced no result");

    // no-window results carry zero fields
    a_nowin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.found |-> r_out.start_res == '0 && r_out.length == '0)
        else $error("no-window result with nonzero fields");

endmodule

### src/mcw_core.sv
// Alphabet set, last-seen positions and best-window tracking for one query.
module mcw_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  mcw_pkg::t_in i_item,
    output mcw_pkg::t_out o_res
);

    logic [mcw_pkg::CHAR_W-1:0]   r_chars [mcw_pkg::MAX_ALPHABET];
    logic [mcw_pkg::POS_W-1:0]    r_lpos  [mcw_pkg::MAX_ALPHABET];
    logic [mcw_pkg::MAX_ALPHABET-1:0] r_valid;
    logic [mcw_pkg::MAX_ALPHABET-1:0] r_seen;
    logic [mcw_pkg::POS_W-1:0]    r_pos;
    logic [mcw_pkg::POS_W-1:0]    r_best_start;
    logic [mcw_pkg::LEN_W-1:0]    r_best_len;
    logic                         r_best_found;

    logic [mcw_pkg::MAX_ALPHABET-1:0] match;
    logic [mcw_pkg::MAX_ALPHABET-1:0] free_oh;
    logic [mcw_pkg::MAX_ALPHABET-1:0] n_seen;
    logic [mcw_pkg::POS_W-1:0]    new_lpos [mcw_pkg::MAX_ALPHABET];
    logic [mcw_pkg::POS_W-1:0]    tree [1:2*mcw_pkg::MAX_ALPHABET-1];
    logic [mcw_pkg::POS_W-1:0]    oldest;
    logic [mcw_pkg::LEN_W-1:0]    cand_len;
    logic                         is_text;
    logic                         add;
    logic                         any_valid;
    logic                         all_seen;
    logic                         take;

    always_comb begin
        for (int i = 0; i < mcw_pkg::MAX_ALPHABET; i++) begin
            match[i]    = r_valid[i] && (r_chars[i] == i_item.ch);
            new_lpos[i] = match[i] ? r_pos : r_lpos[i];
        end
    end

    // lowest free slot, one-hot
    assign free_oh   = ~r_valid & (r_valid + 1'b1);
    assign is_text   = (i_item.op == mcw_pkg::OP_TEXT);
    assign add       = !is_text && !(|match) && !(&r_valid);
    assign n_seen    = r_seen | match;
    assign any_valid = |r_valid;
    assign all_seen  = &(n_seen | ~r_valid);

    // min tree over last-seen positions; empty slots read as all ones
    always_comb begin
        for (int i = 0; i < mcw_pkg::MAX_ALPHABET; i++) begin
            tree[mcw_pkg::MAX_ALPHABET + i] = r_valid[i] ? new_lpos[i] : '1;
        end
        for (int k = mcw_pkg::MAX_ALPHABET - 1; k >= 1; k--) begin
            tree[k] = (tree[2*k] < tree[2*k+1]) ? tree[2*k] : tree[2*k+1];
        end
    end

    assign oldest   = tree[1];
    assign cand_len = {1'b0, r_pos} - {1'b0, oldest} + mcw_pkg::LEN_W'(1);
    assign take     = is_text && any_valid && all_seen &&
                      (!r_best_found || (cand_len < r_best_len));

    always_comb begin
        if (!any_valid) begin
            o_res = '{found: 1'b1, start_res: '0, length: '0};
        end else if (take) begin
            o_res = '{found: 1'b1, start_res: oldest, length: cand_len};
        end else if (r_best_found) begin
            o_res = '{found: 1'b1, start_res: r_best_start, length: r_best_len};
        end else begin
            o_res = '{found: 1'b0, start_res: '0, length: '0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_seen       <= '0;
            r_pos        <= '0;
            r_best_found <= 1'b0;
        end else if (i_en) begin
            if (is_text && i_item.last) begin
                r_valid      <= '0;
                r_seen       <= '0;
                r_pos        <= '0;
                r_best_found <= 1'b0;
            end else if (is_text) begin
                r_seen <= n_seen;
                if (r_pos != mcw_pkg::MAX_POS) begin
                    r_pos <= r_pos + 1'b1;
                end
                if (take) begin
                    r_best_found <= 1'b1;
                end
            end else if (add) begin
                r_valid <= r_valid | free_oh;
                r_seen  <= r_seen & ~free_oh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && take) begin
            r_best_start <= oldest;
            r_best_len   <= cand_len;
        end
        for (int i = 0; i < mcw_pkg::MAX_ALPHABET; i++) begin
            if (i_en && add && free_oh[i]) begin
                r_chars[i] <= i_item.ch;
            end
            if (i_en && is_text && match[i]) begin
                r_lpos[i] <= r_pos;
            end
        end
    end

endmodule

### dv/mcw_checker.sv
`timescale 1ns / 100ps
// Checker for the minimum covering window block: tracks the query and compares results.
module mcw_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  mcw_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  mcw_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_waiting
);

    logic [mcw_pkg::CHAR_W-1:0] sym_ch   [mcw_pkg::MAX_ALPHABET];
    logic                       sym_vld  [mcw_pkg::MAX_ALPHABET];
    logic                       sym_seen [mcw_pkg::MAX_ALPHABET];
    logic [mcw_pkg::POS_W-1:0]  sym_pos  [mcw_pkg::MAX_ALPHABET];
    logic [mcw_pkg::POS_W-1:0]  text_pos;
    logic [mcw_pkg::POS_W-1:0]  best_start;
    logic [mcw_pkg::LEN_W-1:0]  best_len;
    logic                       best_found;

    mcw_pkg::t_out expected_windows [$];
    int            fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void clear_query();
        for (int i = 0; i < mcw_pkg::MAX_ALPHABET; i++) begin
            sym_ch[i]   = '0;
            sym_vld[i]  = 1'b0;
            sym_seen[i] = 1'b0;
            sym_pos[i]  = '0;
        end
        text_pos   = '0;
        best_start = '0;
        best_len   = '1;
        best_found = 1'b0;
    endfunction

    // Applies one accepted input transaction; a closing text byte queues a window.
    function automatic void update_window(input mcw_pkg::t_in item);
        logic                      dup;
        int                        free_slot;
        logic                      any_sym;
        logic                      all_seen;
        logic [mcw_pkg::POS_W-1:0] oldest;
        logic [mcw_pkg::LEN_W-1:0] span;
        mcw_pkg::t_out             res;
        if (item.op == mcw_pkg::OP_ALPHA) begin
            dup       = 1'b0;
            free_slot = -1;
            for (int i = 0; i < mcw_pkg::MAX_ALPHABET; i++) begin
                if (sym_vld[i]) begin
                    if (sym_ch[i] == item.ch) dup = 1'b1;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (!dup && free_slot >= 0) begin
                sym_ch[free_slot]   = item.ch;
                sym_vld[free_slot]  = 1'b1;
                sym_seen[free_slot] = 1'b0;
            end
            return;
        end
        for (int i = 0; i < mcw_pkg::MAX_ALPHABET; i++) begin
            if (sym_vld[i] && sym_ch[i] == item.ch) begin
                sym_seen[i] = 1'b1;
                sym_pos[i]  = text_pos;
            end
        end
        any_sym  = 1'b0;
        all_seen = 1'b1;
        oldest   = '0;
        for (int i = 0; i < mcw_pkg::MAX_ALPHABET; i++) begin
            if (sym_vld[i]) begin
                if (!sym_seen[i]) begin
                    all_seen = 1'b0;
                end else if (!any_sym || sym_pos[i] < oldest) begin
                    oldest = sym_pos[i];
                end
                any_sym = 1'b1;
            end
        end
        if (any_sym && all_seen) begin
            span = {1'b0, text_pos} - {1'b0, oldest} + 1'b1;
            // strictly shorter only, so the earliest window of a length wins
            if (!best_found || span < best_len) begin
                best_found = 1'b1;
                best_start = oldest;
                best_len   = span;
            end
        end
        if (text_pos != mcw_pkg::MAX_POS) text_pos++;
        if (!item.last) return;
        res = '0;
        if (!any_sym) begin
            res.found = 1'b1;
        end else if (best_found) begin
            res.found     = 1'b1;
            res.start_res = best_start;
            res.length    = best_len;
        end
        expected_windows.push_back(res);
        clear_query();
    endfunction

    task automatic report(input string msg);
        fail_count++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task automatic check_result(input mcw_pkg::t_out got);
        mcw_pkg::t_out want;
        if (expected_windows.size() == 0) begin
            report($sformatf("result with none pending: found=%0d start=%0d length=%0d",
                             got.found, got.start_res, got.length));
            return;
        end
        want = expected_windows.pop_front();
        if (got.found !== want.found)
            report($sformatf("found: expected %0d, got %0d", want.found, got.found));
        if (got.start_res !== want.start_res)
            report($sformatf("start_res: expected %0d, got %0d",
                             want.start_res, got.start_res));
        if (got.length !== want.length)
            report($sformatf("length: expected %0d, got %0d", want.length, got.length));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_query();
            expected_windows.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result(i_out_data);
            if (i_in_valid && !i_in_stall) update_window(i_in_data);
        end
        o_waiting <= expected_windows.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the minimum covering window block: stimulus, idling and verdict.
module tb_top;

    localparam int RANDOM_ITEMS = 1050;
    localparam int IDLE_LIMIT   = 2000;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_stall = 1'b0;
    mcw_pkg::t_in  i_in    = '0;
    logic          o_stall;
    logic          o_valid;
    mcw_pkg::t_out o_out;

    int   fail_count;
    int   waiting;
    logic calm         = 1'b0;
    int   stall_left   = 0;
    int   quiet_cycles = 0;
    int   items_sent   = 0;

    minimum_covering_window DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    mcw_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_in),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_out),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly none, sometimes a few cycles, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin : stall_gen
        int n;
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            n = idle_len();
            i_stall <= (n > 0);
            if (n > 0) stall_left <= n - 1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a rising edge; returns at the edge that accepts the transaction.
    task automatic send_item(input logic op, input logic [mcw_pkg::CHAR_W-1:0] ch,
                             input logic fin);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in    <= '{op: op, ch: ch, last: fin};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
    endtask

    task automatic run_query();
        logic [mcw_pkg::CHAR_W-1:0] alpha [$];
        logic [mcw_pkg::CHAR_W-1:0] c;
        logic [mcw_pkg::CHAR_W-1:0] extra;
        int                         k;
        int                         n;
        int                         r;
        r = $urandom_range(0, 99);
        if (r < 4) k = 0;
        else if (r < 85) k = $urandom_range(1, 5);
        else k = $urandom_range(12, 20);    // can fill the set and overflow it
        for (int i = 0; i < k; i++) begin
            c = mcw_pkg::CHAR_W'($urandom_range(0, 255));
            alpha.push_back(c);
            send_item(mcw_pkg::OP_ALPHA, c, ($urandom_range(0, 7) == 0));
            if ($urandom_range(0, 5) == 0) send_item(mcw_pkg::OP_ALPHA, c, 1'b0);
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 25);
        for (int i = 0; i < n; i++) begin
            if (alpha.size() > 0 && $urandom_range(0, 4) != 0)
                c = alpha[$urandom_range(0, alpha.size() - 1)];
            else
                c = mcw_pkg::CHAR_W'($urandom_range(0, 255));
            if ($urandom_range(0, 39) == 0) begin
                extra = mcw_pkg::CHAR_W'($urandom_range(0, 255));
                alpha.push_back(extra);
                send_item(mcw_pkg::OP_ALPHA, extra, 1'b0);
            end
            send_item(mcw_pkg::OP_TEXT, c, (i == n - 1));
        end
    endtask

    initial begin
        int  first;
        logic pressed;
        pressed = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty alphabet
        send_item(mcw_pkg::OP_TEXT, 8'h00, 1'b1);
        // last bit on alphabet ignored, duplicate, byte outside the set
        send_item(mcw_pkg::OP_ALPHA, 8'h41, 1'b1);
        send_item(mcw_pkg::OP_ALPHA, 8'hFF, 1'b0);
        send_item(mcw_pkg::OP_ALPHA, 8'h41, 1'b0);
        send_item(mcw_pkg::OP_TEXT, 8'hFF, 1'b0);
        send_item(mcw_pkg::OP_TEXT, 8'h00, 1'b0);
        send_item(mcw_pkg::OP_TEXT, 8'h41, 1'b0);
        send_item(mcw_pkg::OP_TEXT, 8'hFF, 1'b1);
        // no covering window
        send_item(mcw_pkg::OP_ALPHA, 8'h80, 1'b0);
        send_item(mcw_pkg::OP_TEXT, 8'h7F, 1'b1);
        // alphabet grows in the middle of the text
        send_item(mcw_pkg::OP_ALPHA, 8'h01, 1'b0);
        send_item(mcw_pkg::OP_TEXT, 8'h01, 1'b0);
        send_item(mcw_pkg::OP_ALPHA, 8'hFE, 1'b0);
        send_item(mcw_pkg::OP_TEXT, 8'h00, 1'b0);
        send_item(mcw_pkg::OP_TEXT, 8'hFE, 1'b0);
        send_item(mcw_pkg::OP_TEXT, 8'h01, 1'b1);
        // equal-length later window must not replace the earlier one
        send_item(mcw_pkg::OP_ALPHA, 8'h00, 1'b0);
        send_item(mcw_pkg::OP_TEXT, 8'h00, 1'b0);
        send_item(mcw_pkg::OP_TEXT, 8'h00, 1'b1);
        wait_results();

        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            if (!pressed && items_sent - first >= RANDOM_ITEMS / 2) begin
                wait_results();
                pressed = 1'b1;
            end
            calm <= ($urandom_range(0, 5) == 0);
            run_query();
        end
        wait_results();
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
